[sv/assert_macros.svh]
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define LSC_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LSC_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSC_ASSERT(name, clk, rst, prop, msg)
`define LSC_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

[sv/lsc_pkg.sv]
`default_nettype none
package lsc_pkg;
  localparam int OC_LEFT   = 0;
  localparam int OC_RIGHT  = 1;
  localparam int OC_TOP    = 2;
  localparam int OC_BOTTOM = 3;

  typedef logic [3:0] ocode_t;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_TOP    = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_BOTTOM = 2'd3
  } reg_idx_t;
endpackage
`default_nettype wire

[sv/lsc_step.sv]
`default_nettype none
module lsc_step #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [COORD_BITS+FRAC_BITS-1:0] in_x1,
  input  logic signed [COORD_BITS+FRAC_BITS-1:0] in_y1,
  input  logic signed [COORD_BITS+FRAC_BITS-1:0] in_x2,
  input  logic signed [COORD_BITS+FRAC_BITS-1:0] in_y2,
  input  logic signed [COORD_BITS-1:0]         left_edge,
  input  logic signed [COORD_BITS-1:0]         top_edge,
  input  logic signed [COORD_BITS-1:0]         right_edge,
  input  logic signed [COORD_BITS-1:0]         bottom_edge,
  output logic                                 out_valid,
  output logic signed [COORD_BITS+FRAC_BITS-1:0] out_x1,
  output logic signed [COORD_BITS+FRAC_BITS-1:0] out_y1,
  output logic signed [COORD_BITS+FRAC_BITS-1:0] out_x2,
  output logic signed [COORD_BITS+FRAC_BITS-1:0] out_y2
);
  import lsc_pkg::*;

  localparam int W  = COORD_BITS + FRAC_BITS;
  localparam int M  = W + 1;
  localparam int H  = (M + 1) / 2;
  localparam int L  = M - H;
  localparam int SW = 6 * W + 5;

  logic signed [W-1:0] wl, wt, wr, wb;
  assign wl = {left_edge, {FRAC_BITS{1'b0}}};
  assign wt = {top_edge, {FRAC_BITS{1'b0}}};
  assign wr = {right_edge, {FRAC_BITS{1'b0}}};
  assign wb = {bottom_edge, {FRAC_BITS{1'b0}}};

  function automatic ocode_t ocode(input logic signed [W-1:0] x, input logic signed [W-1:0] y);
    ocode_t c;
    c = '0;
    if (x < wl) c[OC_LEFT] = 1'b1;
    else if (x > wr) c[OC_RIGHT] = 1'b1;
    if (y < wt) c[OC_TOP] = 1'b1;
    else if (y > wb) c[OC_BOTTOM] = 1'b1;
    return c;
  endfunction

  // stage 0: outcodes
  logic                v0;
  logic signed [W-1:0] x1_0, y1_0, x2_0, y2_0;
  ocode_t              c1_0, c2_0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= in_valid;
    if (en) begin
      x1_0 <= in_x1;
      y1_0 <= in_y1;
      x2_0 <= in_x2;
      y2_0 <= in_y2;
      c1_0 <= ocode(in_x1, in_y1);
      c2_0 <= ocode(in_x2, in_y2);
    end
  end

  // stage 1: pick endpoint and edge, form differences
  logic                done, mv1, isx, neg, dz;
  ocode_t              code;
  logic signed [W-1:0] px, py, ox, oy, edge_v, a0, b0, a1, b1;
  logic signed [M-1:0] n1, n2, dd;
  logic [M-1:0]        ma, mb, md;

  always_comb begin
    done = ((c1_0 | c2_0) == 4'd0) || ((c1_0 & c2_0) != 4'd0);
    mv1  = (c1_0 != 4'd0);
    code = mv1 ? c1_0 : c2_0;
    px   = mv1 ? x1_0 : x2_0;
    py   = mv1 ? y1_0 : y2_0;
    ox   = mv1 ? x2_0 : x1_0;
    oy   = mv1 ? y2_0 : y1_0;
    if (code[OC_LEFT]) begin
      isx = 1'b1; edge_v = wl;
    end else if (code[OC_TOP]) begin
      isx = 1'b0; edge_v = wt;
    end else if (code[OC_RIGHT]) begin
      isx = 1'b1; edge_v = wr;
    end else begin
      isx = 1'b0; edge_v = wb;
    end
    a0 = isx ? px : py;
    b0 = isx ? py : px;
    a1 = isx ? ox : oy;
    b1 = isx ? oy : ox;
    n1 = {edge_v[W-1], edge_v} - {a0[W-1], a0};
    n2 = {b1[W-1], b1} - {b0[W-1], b0};
    dd = {a1[W-1], a1} - {a0[W-1], a0};
    ma = n1[M-1] ? (~n1 + M'(1)) : n1;
    mb = n2[M-1] ? (~n2 + M'(1)) : n2;
    md = dd[M-1] ? (~dd + M'(1)) : dd;
    neg = n1[M-1] ^ n2[M-1] ^ dd[M-1];
    dz  = (dd == '0);
  end

  logic          v1;
  logic [SW-1:0] s1;
  logic [M-1:0]  ma1, mb1, md1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
    if (en) begin
      s1  <= {x1_0, y1_0, x2_0, y2_0, edge_v, b0, done, mv1, isx, neg, dz};
      ma1 <= ma;
      mb1 <= mb;
      md1 <= md;
    end
  end

  // stage 2: partial products
  logic           v2;
  logic [SW-1:0]  s2;
  logic [M-1:0]   md2;
  logic [2*H-1:0] pp_ll;
  logic [M-1:0]   pp_lh, pp_hl;
  logic [2*L-1:0] pp_hh;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      s2    <= s1;
      md2   <= md1;
      pp_ll <= ma1[H-1:0] * mb1[H-1:0];
      pp_lh <= ma1[H-1:0] * mb1[M-1:H];
      pp_hl <= ma1[M-1:H] * mb1[H-1:0];
      pp_hh <= ma1[M-1:H] * mb1[M-1:H];
    end
  end

  // stage 3: product sum
  logic           v3;
  logic [SW-1:0]  s3;
  logic [M-1:0]   md3;
  logic [2*M-1:0] p3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      s3  <= s2;
      md3 <= md2;
      p3  <= (2*M)'(pp_ll) + ((2*M)'(pp_lh) << H) + ((2*M)'(pp_hl) << H)
           + ((2*M)'(pp_hh) << (2*H));
    end
  end

  // stage 4 and on: saturation check, then one quotient bit per stage
  logic          v_d   [0:M];
  logic [SW-1:0] s_d   [0:M];
  logic [M-1:0]  md_d  [0:M];
  logic [M-1:0]  rem_d [0:M];
  logic [M-1:0]  plo_d [0:M];
  logic [M-1:0]  q_d   [0:M];
  logic          sat_d [0:M];

  always_ff @(posedge clk) begin
    if (rst) v_d[0] <= 1'b0;
    else if (en) v_d[0] <= v3;
    if (en) begin
      s_d[0]   <= s3;
      md_d[0]  <= md3;
      rem_d[0] <= p3[2*M-1:M];
      plo_d[0] <= p3[M-1:0];
      q_d[0]   <= '0;
      sat_d[0] <= (p3[2*M-1:M] >= md3);
    end
  end

  for (genvar k = 0; k < M; k++) begin : g_div
    logic [M:0] sh, diff;
    logic       ge;
    assign sh   = {rem_d[k], plo_d[k][M-1-k]};
    assign diff = sh - {1'b0, md_d[k]};
    assign ge   = (sh >= {1'b0, md_d[k]});

    always_ff @(posedge clk) begin
      if (rst) v_d[k+1] <= 1'b0;
      else if (en) v_d[k+1] <= v_d[k];
      if (en) begin
        s_d[k+1]   <= s_d[k];
        md_d[k+1]  <= md_d[k];
        plo_d[k+1] <= plo_d[k];
        sat_d[k+1] <= sat_d[k];
        rem_d[k+1] <= ge ? diff[M-1:0] : sh[M-1:0];
        q_d[k+1]   <= q_d[k] | (ge ? (M'(1) << (M-1-k)) : M'(0));
      end
    end
  end

  // last stage: apply crossing
  logic [SW-1:0]       sf;
  logic signed [W-1:0] fx1, fy1, fx2, fy2, fedge, fb0, nbc, nbv;
  logic                fdone, fmv1, fisx, fneg, fdz;
  logic [M:0]          qe;
  logic signed [W+2:0] b0e, qee, nb, fmax, fmin;

  assign sf    = s_d[M];
  assign fx1   = sf[6*W+4 -: W];
  assign fy1   = sf[5*W+4 -: W];
  assign fx2   = sf[4*W+4 -: W];
  assign fy2   = sf[3*W+4 -: W];
  assign fedge = sf[2*W+4 -: W];
  assign fb0   = sf[W+4 -: W];
  assign fdone = sf[4];
  assign fmv1  = sf[3];
  assign fisx  = sf[2];
  assign fneg  = sf[1];
  assign fdz   = sf[0];
  assign fmax  = {4'b0000, {(W-1){1'b1}}};
  assign fmin  = {4'b1111, {(W-1){1'b0}}};

  always_comb begin
    qe  = sat_d[M] ? {1'b1, M'(0)} : {1'b0, q_d[M]};
    b0e = {{3{fb0[W-1]}}, fb0};
    qee = {1'b0, qe};
    nb  = fneg ? (b0e - qee) : (b0e + qee);
    if (nb > fmax) nbc = {1'b0, {(W-1){1'b1}}};
    else if (nb < fmin) nbc = {1'b1, {(W-1){1'b0}}};
    else nbc = nb[W-1:0];
    nbv = fdz ? fb0 : nbc;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v_d[M];
    if (en) begin
      out_x1 <= fx1;
      out_y1 <= fy1;
      out_x2 <= fx2;
      out_y2 <= fy2;
      if (!fdone) begin
        if (fmv1) begin
          out_x1 <= fisx ? fedge : nbv;
          out_y1 <= fisx ? nbv : fedge;
        end else begin
          out_x2 <= fisx ? fedge : nbv;
          out_y2 <= fisx ? nbv : fedge;
        end
      end
    end
  end
endmodule
`default_nettype wire

[sv/line_segment_clipper_unit.sv]
// Cohen-Sutherland segment clipper. Takes one segment per cycle while the
// output is not stalled and returns one result per segment, in order. It
// runs four identical clip steps, each dominated by a restoring divider
// that resolves one quotient bit per stage. Any stall on the output freezes
// the whole pipeline. m_tuser is the visible flag; rejected segments return
// all-zero coordinates. Window registers must be written only while no item
// is in flight; the block itself does not enforce this.
`default_nettype none
`include "assert_macros.svh"
module line_segment_clipper_unit #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // start_x, start_y, end_x, end_y
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // clip_start_x, clip_start_y, clip_end_x, clip_end_y
  output logic [((4*COORD_BITS+7)/8)*8-1:0]      m_tdata,
  // visible
  output logic                                   m_tuser,
  input  logic                                   cfg_we,
  input  logic [1:0]                             cfg_addr,
  input  logic [COORD_BITS-1:0]                  cfg_data
);
  import lsc_pkg::*;

  localparam int W  = COORD_BITS + FRAC_BITS;
  localparam int TW = ((4*COORD_BITS+7)/8)*8;
  localparam int CB = COORD_BITS;

  logic signed [CB-1:0] left_edge, top_edge, right_edge, bottom_edge;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_edge   <= '0;
      top_edge    <= '0;
      right_edge  <= CB'(639);
      bottom_edge <= CB'(479);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_LEFT:   left_edge   <= cfg_data;
        REG_TOP:    top_edge    <= cfg_data;
        REG_RIGHT:  right_edge  <= cfg_data;
        REG_BOTTOM: bottom_edge <= cfg_data;
        default:    ;
      endcase
    end
  end

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic                sv  [0:4];
  logic signed [W-1:0] sx1 [0:4];
  logic signed [W-1:0] sy1 [0:4];
  logic signed [W-1:0] sx2 [0:4];
  logic signed [W-1:0] sy2 [0:4];

  assign sv[0]  = s_tvalid;
  assign sx1[0] = {s_tdata[CB-1:0], {FRAC_BITS{1'b0}}};
  assign sy1[0] = {s_tdata[2*CB-1:CB], {FRAC_BITS{1'b0}}};
  assign sx2[0] = {s_tdata[3*CB-1:2*CB], {FRAC_BITS{1'b0}}};
  assign sy2[0] = {s_tdata[4*CB-1:3*CB], {FRAC_BITS{1'b0}}};

  for (genvar i = 0; i < 4; i++) begin : g_step
    lsc_step #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
    ) u_step (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .in_valid   (sv[i]),
      .in_x1      (sx1[i]),
      .in_y1      (sy1[i]),
      .in_x2      (sx2[i]),
      .in_y2      (sy2[i]),
      .left_edge  (left_edge),
      .top_edge   (top_edge),
      .right_edge (right_edge),
      .bottom_edge(bottom_edge),
      .out_valid  (sv[i+1]),
      .out_x1     (sx1[i+1]),
      .out_y1     (sy1[i+1]),
      .out_x2     (sx2[i+1]),
      .out_y2     (sy2[i+1])
    );
  end

  logic signed [W-1:0] wl, wt, wr, wb;
  assign wl = {left_edge, {FRAC_BITS{1'b0}}};
  assign wt = {top_edge, {FRAC_BITS{1'b0}}};
  assign wr = {right_edge, {FRAC_BITS{1'b0}}};
  assign wb = {bottom_edge, {FRAC_BITS{1'b0}}};

  function automatic ocode_t ocode(input logic signed [W-1:0] x, input logic signed [W-1:0] y);
    ocode_t c;
    c = '0;
    if (x < wl) c[OC_LEFT] = 1'b1;
    else if (x > wr) c[OC_RIGHT] = 1'b1;
    if (y < wt) c[OC_TOP] = 1'b1;
    else if (y > wb) c[OC_BOTTOM] = 1'b1;
    return c;
  endfunction

  // round half up, saturate to coordinate range
  function automatic logic [CB-1:0] rnd(input logic signed [W-1:0] v);
    logic signed [W:0]  t;
    logic signed [CB:0] r;
    t = {v[W-1], v} + ((W+1)'(1) << (FRAC_BITS-1));
    r = t[W:FRAC_BITS];
    if (r[CB] != r[CB-1]) return r[CB] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
    return r[CB-1:0];
  endfunction

  logic                fv;
  logic signed [W-1:0] fx1, fy1, fx2, fy2;
  ocode_t              fc1, fc2;

  always_ff @(posedge clk) begin
    if (rst) fv <= 1'b0;
    else if (en) fv <= sv[4];
    if (en) begin
      fx1 <= sx1[4];
      fy1 <= sy1[4];
      fx2 <= sx2[4];
      fy2 <= sy2[4];
      fc1 <= ocode(sx1[4], sy1[4]);
      fc2 <= ocode(sx2[4], sy2[4]);
    end
  end

  logic vis;
  assign vis = ((fc1 | fc2) == 4'd0);

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= fv;
    if (en) begin
      m_tuser <= vis;
      m_tdata <= vis ? TW'({rnd(fy2), rnd(fx2), rnd(fy1), rnd(fx1)}) : '0;
    end
  end

  logic signed [CB-1:0] o_sx, o_sy, o_ex, o_ey;
  assign o_sx = m_tdata[CB-1:0];
  assign o_sy = m_tdata[2*CB-1:CB];
  assign o_ex = m_tdata[3*CB-1:2*CB];
  assign o_ey = m_tdata[4*CB-1:3*CB];

  `LSC_ASSERT(a_vis_in_window, clk, rst, m_tvalid && m_tuser |-> (o_sx >= left_edge) && (o_sx <= right_edge) && (o_ex >= left_edge) && (o_ex <= right_edge) && (o_sy >= top_edge) && (o_sy <= bottom_edge) && (o_ey >= top_edge) && (o_ey <= bottom_edge), "visible result outside window")
  `LSC_ASSERT(a_reject_zero, clk, rst, m_tvalid && !m_tuser |-> m_tdata == '0, "rejected result not zeroed")
endmodule
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import lsc_pkg::*;

  localparam int CW = 16;
  localparam int FW = 16;
  localparam longint FX_HI = (longint'(1) << (CW + FW - 1)) - 1;
  localparam longint FX_LO = -(longint'(1) << (CW + FW - 1));
  localparam longint Q_SAT = longint'(1) << (CW + FW + 1);

  typedef struct packed {
    logic signed [CW-1:0] ey, ex, sy, sx;
  } seg_t;

  typedef struct {
    bit vis;
    logic [CW-1:0] sx, sy, ex, ey;
  } clip_t;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready;
  logic [63:0] s_tdata = '0;
  logic m_tvalid, m_tready = 0, m_tuser;
  logic [63:0] m_tdata;
  logic cfg_we = 0;
  logic [1:0] cfg_addr = '0;
  logic [CW-1:0] cfg_data = '0;

  line_segment_clipper_unit i_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  seg_t segs_pending[$];
  clip_t clips_due[$];
  longint win[4];
  int tx_idle = 6, rx_idle = 75;
  int stall_left = 0;
  int errs = 0;

  function automatic void add_seg(seg_t s);
    segs_pending.insert(segs_pending.size(), s);
  endfunction

  function automatic void add_due(clip_t c);
    clips_due.insert(clips_due.size(), c);
  endfunction

  function automatic longint crossing(longint a0, longint b0, longint a1, longint b1,
                                      longint edge_v);
    longint n1, n2, d, q;
    logic signed [127:0] p;
    logic [127:0] mp, md, mq;
    bit neg;
    n1 = edge_v - a0;
    n2 = b1 - b0;
    d = a1 - a0;
    if (d == 0) return b0;
    p = 128'(n1) * 128'(n2);
    mp = p < 0 ? -p : p;
    md = d < 0 ? 128'(-d) : 128'(d);
    mq = mp / md;
    q = mq > 128'(Q_SAT) ? Q_SAT : longint'(mq);
    neg = (p < 0) != (d < 0);
    q = neg ? b0 - q : b0 + q;
    return q > FX_HI ? FX_HI : (q < FX_LO ? FX_LO : q);
  endfunction

  function automatic ocode_t region(longint x, longint y, longint w[4]);
    ocode_t c;
    c = '0;
    if (x < w[0]) c[OC_LEFT] = 1;
    else if (x > w[2]) c[OC_RIGHT] = 1;
    if (y < w[1]) c[OC_TOP] = 1;
    else if (y > w[3]) c[OC_BOTTOM] = 1;
    return c;
  endfunction

  function automatic logic [CW-1:0] to_pixel(longint v);
    longint r;
    r = (v + (longint'(1) << (FW - 1))) >>> FW;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[CW-1:0];
  endfunction

  function automatic clip_t clip_segment(seg_t s);
    longint w[4], px[2], py[2];
    ocode_t c[2];
    int k;
    clip_t r;
    for (int i = 0; i < 4; i++) w[i] = win[i] <<< FW;
    px[0] = longint'(s.sx) <<< FW;
    py[0] = longint'(s.sy) <<< FW;
    px[1] = longint'(s.ex) <<< FW;
    py[1] = longint'(s.ey) <<< FW;
    c[0] = region(px[0], py[0], w);
    c[1] = region(px[1], py[1], w);
    for (int step = 0; step < 4; step++) begin
      if ((c[0] | c[1]) == 0 || (c[0] & c[1]) != 0) break;
      k = c[0] != 0 ? 0 : 1;
      if (c[k][OC_LEFT]) begin
        py[k] = crossing(px[k], py[k], px[1-k], py[1-k], w[0]);
        px[k] = w[0];
      end else if (c[k][OC_TOP]) begin
        px[k] = crossing(py[k], px[k], py[1-k], px[1-k], w[1]);
        py[k] = w[1];
      end else if (c[k][OC_RIGHT]) begin
        py[k] = crossing(px[k], py[k], px[1-k], py[1-k], w[2]);
        px[k] = w[2];
      end else begin
        px[k] = crossing(py[k], px[k], py[1-k], px[1-k], w[3]);
        py[k] = w[3];
      end
      c[k] = region(px[k], py[k], w);
    end
    r = '{0, 0, 0, 0, 0};
    if ((c[0] | c[1]) == 0) begin
      r.vis = 1;
      r.sx = to_pixel(px[0]);
      r.sy = to_pixel(py[0]);
      r.ex = to_pixel(px[1]);
      r.ey = to_pixel(py[1]);
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else begin
      if (s_tvalid && s_tready) add_due(clip_segment(seg_t'(s_tdata)));
      if (!s_tvalid || s_tready) begin
        if (segs_pending.size() > 0 && $urandom_range(99) >= tx_idle) begin
          s_tdata <= segs_pending.pop_front();
          s_tvalid <= 1;
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    clip_t e;
    logic [CW-1:0] got[4];
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48]};
        if (clips_due.size() == 0) begin
          $error("unexpected item: visible=%0d data=%h", m_tuser, m_tdata);
          errs++;
        end else begin
          e = clips_due.pop_front();
          if (m_tuser !== e.vis) begin
            $error("visible: expected %0d got %0d", e.vis, m_tuser); errs++;
          end
          if (got[0] !== e.sx) begin
            $error("clip_start_x: expected %0d got %0d", $signed(e.sx), $signed(got[0]));
            errs++;
          end
          if (got[1] !== e.sy) begin
            $error("clip_start_y: expected %0d got %0d", $signed(e.sy), $signed(got[1]));
            errs++;
          end
          if (got[2] !== e.ex) begin
            $error("clip_end_x: expected %0d got %0d", $signed(e.ex), $signed(got[2]));
            errs++;
          end
          if (got[3] !== e.ey) begin
            $error("clip_end_y: expected %0d got %0d", $signed(e.ey), $signed(got[3]));
            errs++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready <= 0;
      end else begin
        m_tready <= $urandom_range(99) >= rx_idle;
      end
    end
  end

  function automatic logic signed [CW-1:0] pick(longint lo, longint hi);
    longint a, b, v;
    if ($urandom_range(3) == 0) return CW'($urandom);
    a = lo < hi ? lo : hi;
    b = lo < hi ? hi : lo;
    v = a - 200 + longint'($urandom_range(0, 32'(b - a + 400)));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[CW-1:0];
  endfunction

  task automatic set_edges(longint l, longint t, longint r, longint b);
    longint v[4];
    v = '{l, t, r, b};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_we <= 1;
      cfg_addr <= reg_idx_t'(i);
      cfg_data <= v[i][CW-1:0];
      win[i] = longint'($signed(v[i][CW-1:0]));
    end
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain;
    while (segs_pending.size() > 0 || clips_due.size() > 0 || s_tvalid) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    longint windows[6][4];
    seg_t s;
    windows = '{'{0, 0, 639, 479}, '{-32768, -32768, 32767, 32767},
                '{-100, -50, 100, 50}, '{5, 5, 5, 5},
                '{300, 200, -300, -200}, '{0, 0, 0, 0}};
    win = '{0, 0, 639, 479};
    repeat (5) @(posedge clk);
    rst <= 0;
    // directed set on the reset window
    add_seg('{479, 639, 0, 0});
    add_seg('{-32768, -32768, -32768, -32768});
    add_seg('{32767, 32767, 32767, 32767});
    add_seg('{32767, 32767, -32768, -32768});
    add_seg('{-32768, 32767, 32767, -32768});
    add_seg('{100, -10, 100, -5});
    add_seg('{100, 700, 100, 650});
    add_seg('{-5, 100, -1, 100});
    add_seg('{500, 100, 490, 100});
    add_seg('{240, 800, 240, -100});
    add_seg('{600, 320, -100, 320});
    add_seg('{500, 700, -20, -30});
    add_seg('{-50, 700, 600, -10});
    add_seg('{-10, 0, 480, 10});
    add_seg('{480, 640, -1, -1});
    add_seg('{-1, 650, 500, -10});
    add_seg('{0, -1, 1, 0});
    add_seg('{3, 1000, 1, -1000});
    add_seg('{479, 639, 480, 640});
    add_seg('{200, 300, 100, 50});
    for (int ph = 0; ph < 6; ph++) begin
      tx_idle = ph < 2 ? 6 : (ph < 4 ? 75 : 0);
      rx_idle = ph < 2 ? 75 : (ph < 4 ? 6 : 0);
      if (ph > 0) begin
        drain();
        if (ph == 5)
          set_edges(pick(-300, 300), pick(-300, 300), pick(-300, 300), pick(-300, 300));
        else
          set_edges(windows[ph][0], windows[ph][1], windows[ph][2], windows[ph][3]);
      end
      if (ph == 4) stall_left <= 400;
      for (int n = 0; n < 105; n++) begin
        s.sx = pick(win[0], win[2]);
        s.sy = pick(win[1], win[3]);
        s.ex = pick(win[0], win[2]);
        s.ey = pick(win[1], win[3]);
        add_seg(s);
      end
    end
    drain();
    if (errs == 0) begin
      $display("line_segment_clipper_unit verification clean");
    end else begin
      $display("line_segment_clipper_unit verification failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("line_segment_clipper_unit verification failed");
    $finish;
  end
endmodule
`default_nettype wire
